>>> rtl/core/rmad_pkg.sv
`default_nettype none
package rmad_pkg;

    // request codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // width of the running sums and of min_value
    localparam int SUM_W = 44;

    // command from the sequencer to one heap engine
    typedef struct packed {
        logic start;
        logic pop;
    } heap_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/rmad_ram.sv
`default_nettype none
module rmad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 513,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

>>> rtl/core/rmad_heap.sv
`default_nettype none
module rmad_heap #(
    parameter int   DEPTH  = 513,
    parameter int   W      = 32,
    parameter logic IS_MAX = 1'b1,
    localparam int  AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int  CW = $clog2(DEPTH + 1)
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire rmad_pkg::heap_cmd_t cmd,
    input  wire logic signed [W-1:0] push_value,
    output logic                     done,
    output logic signed [W-1:0]      pop_value,
    output logic [CW-1:0]            count,
    output logic signed [W-1:0]      top
);

    localparam int IW = AW + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_UP, S_UP_CMP, S_LAST, S_DN, S_DN_L, S_DN_R, S_DN_DEC
    } state_t;

    state_t               state_reg;
    logic [IW-1:0]        idx_reg, par_reg, best_idx_reg;
    logic [CW-1:0]        cnt_reg, n_reg;
    logic signed [W-1:0]  val_reg, best_val_reg, top_reg, pop_reg;
    logic                 done_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_addr;
    logic [W-1:0]         ram_wd;
    logic [W-1:0]         ram_rd;
    logic signed [W-1:0]  rd_s;
    logic [IW-1:0]        lch, rch, par, n_ext;

    rmad_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wd),
        .rdata (ram_rd)
    );

    // true if x belongs above y
    function automatic logic outranks(input logic signed [W-1:0] x,
                                      input logic signed [W-1:0] y);
        outranks = IS_MAX ? (y < x) : (x < y);
    endfunction

    assign rd_s  = signed'(ram_rd);
    assign lch   = (idx_reg << 1) + IW'(1);
    assign rch   = (idx_reg << 1) + IW'(2);
    assign par   = (idx_reg - IW'(1)) >> 1;
    assign n_ext = IW'(n_reg);

    // memory port
    always_comb
    begin
        ram_we   = 1'b0;
        ram_addr = AW'(idx_reg);
        ram_wd   = val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ram_addr = AW'(cnt_reg - CW'(1));
            end
            S_UP:
            begin
                if (idx_reg == '0)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_addr = AW'(par);
                end
            end
            S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (outranks(val_reg, rd_s))
                begin
                    ram_wd = ram_rd;
                end
            end
            S_LAST:
            begin
                ram_addr = '0;
            end
            S_DN:
            begin
                if (lch < n_ext)
                begin
                    ram_addr = AW'(lch);
                end
                else
                begin
                    ram_we = 1'b1;
                end
            end
            S_DN_L:
            begin
                ram_addr = AW'(rch);
            end
            S_DN_R:
            begin
                ram_addr = AW'(rch);
            end
            S_DN_DEC:
            begin
                ram_we = 1'b1;
                if (best_idx_reg != idx_reg)
                begin
                    ram_wd = best_val_reg;
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sift sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.start)
                    begin
                        if (cmd.pop)
                        begin
                            pop_reg   <= top_reg;
                            n_reg     <= cnt_reg - CW'(1);
                            cnt_reg   <= cnt_reg - CW'(1);
                            state_reg <= S_LAST;
                        end
                        else
                        begin
                            idx_reg   <= IW'(cnt_reg);
                            val_reg   <= push_value;
                            cnt_reg   <= cnt_reg + CW'(1);
                            state_reg <= S_UP;
                        end
                    end
                end
                S_UP:
                begin
                    if (idx_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        par_reg   <= par;
                        state_reg <= S_UP_CMP;
                    end
                end
                S_UP_CMP:
                begin
                    if (outranks(val_reg, rd_s))
                    begin
                        idx_reg   <= par_reg;
                        state_reg <= S_UP;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_LAST:
                begin
                    val_reg   <= rd_s;
                    idx_reg   <= '0;
                    state_reg <= S_DN;
                end
                S_DN:
                begin
                    if (lch < n_ext)
                    begin
                        state_reg <= S_DN_L;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_DN_L:
                begin
                    if (outranks(rd_s, val_reg))
                    begin
                        best_val_reg <= rd_s;
                        best_idx_reg <= lch;
                    end
                    else
                    begin
                        best_val_reg <= val_reg;
                        best_idx_reg <= idx_reg;
                    end
                    state_reg <= (rch < n_ext) ? S_DN_R : S_DN_DEC;
                end
                S_DN_R:
                begin
                    if (outranks(rd_s, best_val_reg))
                    begin
                        best_val_reg <= rd_s;
                        best_idx_reg <= rch;
                    end
                    state_reg <= S_DN_DEC;
                end
                S_DN_DEC:
                begin
                    if (best_idx_reg == idx_reg)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= best_idx_reg;
                        state_reg <= S_DN;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // cached copy of the root
    always_ff @(posedge clk)
    begin
        if (ram_we && ram_addr == '0)
        begin
            top_reg <= signed'(ram_wd);
        end
    end

    assign done      = done_reg;
    assign pop_value = pop_reg;
    assign count     = cnt_reg;
    assign top       = top_reg;

    // the root cache is only refreshed while a request runs
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we)
        else $error("heap written while idle");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("heap count beyond depth");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE)
        else $error("done raised while busy");

endmodule
`default_nettype wire

>>> rtl/core/running_median_abs_deviation.sv
// Running median and minimum of f(x) = sum |x - a_i| + b_i. An insert request
// (action 0) stores a position in one of two heaps held in single-port RAMs
// (CAPACITY/2+1 entries each, no clearing pass after reset) and rebalances
// them; a query request (action 1) returns the lower median and min of f.
// One request is handled at a time. A query goes straight to its result; an insert does
// up to three heap sifts, each one RAM access per cycle, a push reading and comparing
// the parent at each tree level and a pop reading both children and then writing back.
// Every request yields one result; inserts into a full store and queries on
// an empty store return status codes FULL and EMPTY.
`default_nettype none
module running_median_abs_deviation #(
    parameter int CAPACITY      = 1024,
    parameter int POSITION_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic signed [31:0] position,
    input  wire logic signed [31:0] offset,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic signed [31:0]      median,
    output logic signed [43:0]      min_value
);

    localparam int HD = CAPACITY / 2 + 1;
    localparam int CW = $clog2(HD + 1);
    localparam int TW = CW + 1;
    localparam int PW = POSITION_BITS;
    localparam int SW = rmad_pkg::SUM_W;

    typedef enum logic [2:0] {
        S_IDLE, S_W1, S_W2P, S_W2U, S_W3P, S_W3L, S_RESULT
    } state_t;

    state_t                 state_reg;
    rmad_pkg::heap_cmd_t    lo_cmd_reg, up_cmd_reg;
    logic signed [PW-1:0]   push_reg;
    logic signed [SW-1:0]   lsum_reg, ptot_reg, otot_reg;
    logic [1:0]             res_st_reg;
    logic signed [31:0]     res_med_reg;
    logic signed [SW-1:0]   res_f_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_st_reg;
    logic signed [31:0]     out_med_reg;
    logic signed [SW-1:0]   out_f_reg;

    logic                   lo_done, up_done;
    logic signed [PW-1:0]   lo_pop, up_pop, lo_top, up_top, pos_ext;
    logic [CW-1:0]          lo_cnt, up_cnt;
    logic [TW-1:0]          total;
    logic signed [SW-1:0]   pos_w, top_w, f_all;
    logic                   accept;

    // position taken to the stored width
    generate
        if (PW <= 32)
        begin : g_narrow
            assign pos_ext = signed'(position[PW-1:0]);
        end
        else
        begin : g_wide
            assign pos_ext = PW'(position);
        end
    endgenerate

    rmad_heap #(.DEPTH(HD), .W(PW), .IS_MAX(1'b1)) u_lower (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (lo_cmd_reg),
        .push_value (push_reg),
        .done       (lo_done),
        .pop_value  (lo_pop),
        .count      (lo_cnt),
        .top        (lo_top)
    );

    rmad_heap #(.DEPTH(HD), .W(PW), .IS_MAX(1'b0)) u_upper (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (up_cmd_reg),
        .push_value (push_reg),
        .done       (up_done),
        .pop_value  (up_pop),
        .count      (up_cnt),
        .top        (up_top)
    );

    assign total    = TW'(lo_cnt) + TW'(up_cnt);
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign pos_w    = SW'(pos_ext);
    assign top_w    = SW'(lo_top);

    // minimum of f at the lower median
    assign f_all = ptot_reg + otot_reg + (total[0] ? top_w : SW'(0))
                 - (lsum_reg <<< 1);

    // request sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lo_cmd_reg    <= '0;
            up_cmd_reg    <= '0;
            lsum_reg      <= '0;
            ptot_reg      <= '0;
            otot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lo_cmd_reg <= '0;
            up_cmd_reg <= '0;
            if (out_valid_reg && !out_stall && state_reg != S_RESULT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_st_reg  <= rmad_pkg::ST_OK;
                        res_med_reg <= '0;
                        res_f_reg   <= '0;
                        state_reg   <= S_RESULT;
                        if (action == rmad_pkg::ACT_QUERY)
                        begin
                            if (lo_cnt == '0)
                            begin
                                res_st_reg <= rmad_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                res_med_reg <= 32'(lo_top);
                                res_f_reg   <= f_all;
                            end
                        end
                        else if (total >= TW'(CAPACITY))
                        begin
                            res_st_reg <= rmad_pkg::ST_FULL;
                        end
                        else
                        begin
                            ptot_reg  <= ptot_reg + pos_w;
                            otot_reg  <= otot_reg + SW'(offset);
                            push_reg  <= pos_ext;
                            state_reg <= S_W1;
                            if (lo_cnt == '0 || !(lo_top < pos_ext))
                            begin
                                lo_cmd_reg <= '{start: 1'b1, pop: 1'b0};
                                lsum_reg   <= lsum_reg + pos_w;
                            end
                            else
                            begin
                                up_cmd_reg <= '{start: 1'b1, pop: 1'b0};
                            end
                        end
                    end
                end
                S_W1:
                begin
                    if (lo_done || up_done)
                    begin
                        if (TW'(lo_cnt) == TW'(up_cnt) + TW'(2))
                        begin
                            lo_cmd_reg <= '{start: 1'b1, pop: 1'b1};
                            state_reg  <= S_W2P;
                        end
                        else if (TW'(up_cnt) == TW'(lo_cnt) + TW'(1))
                        begin
                            up_cmd_reg <= '{start: 1'b1, pop: 1'b1};
                            state_reg  <= S_W3P;
                        end
                        else
                        begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_W2P:
                begin
                    if (lo_done)
                    begin
                        lsum_reg   <= lsum_reg - SW'(lo_pop);
                        push_reg   <= lo_pop;
                        up_cmd_reg <= '{start: 1'b1, pop: 1'b0};
                        state_reg  <= S_W2U;
                    end
                end
                S_W2U:
                begin
                    if (up_done)
                    begin
                        if (TW'(up_cnt) == TW'(lo_cnt) + TW'(1))
                        begin
                            up_cmd_reg <= '{start: 1'b1, pop: 1'b1};
                            state_reg  <= S_W3P;
                        end
                        else
                        begin
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_W3P:
                begin
                    if (up_done)
                    begin
                        lsum_reg   <= lsum_reg + SW'(up_pop);
                        push_reg   <= up_pop;
                        lo_cmd_reg <= '{start: 1'b1, pop: 1'b0};
                        state_reg  <= S_W3L;
                    end
                end
                S_W3L:
                begin
                    if (lo_done)
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_st_reg    <= res_st_reg;
                        out_med_reg   <= res_med_reg;
                        out_f_reg     <= res_f_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = out_st_reg;
    assign median    = out_med_reg;
    assign min_value = out_f_reg;

    // halves stay balanced between requests
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> (lo_cnt == up_cnt) ||
                                (TW'(lo_cnt) == TW'(up_cnt) + TW'(1)))
        else $error("heaps out of balance");
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> total <= TW'(CAPACITY))
        else $error("store beyond capacity");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_st_reg != 2'd3)
        else $error("undefined status code");
    a_one_heap: assert property (@(posedge clk) disable iff (!rst_n)
        !(lo_cmd_reg.start && up_cmd_reg.start))
        else $error("both heaps started together");
    // lower half never reaches above the upper half
    a_halves_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE && lo_cnt != '0 && up_cnt != '0 |-> !(up_top < lo_top))
        else $error("heap halves out of order");

endmodule
`default_nettype wire

>>> test/running_median_abs_deviation_tb.sv
`timescale 1ns / 100ps
module running_median_abs_deviation_tb;

    localparam int CAPACITY   = 1024;
    localparam int IDLE_LIMIT = 20000;
    localparam int RAND_ITEMS = 1150;

    typedef struct {
        logic [1:0]         st;
        logic signed [31:0] med;
        logic signed [43:0] mv;
    } answer_t;

    typedef struct {
        logic               act;
        logic signed [31:0] pos;
        logic signed [31:0] off;
        bit                 typed;
        logic [1:0]         st;
        logic signed [31:0] med;
        logic signed [43:0] mv;
    } stim_row_t;

    // directed requests; typed answers only where obvious
    localparam int DIR_ROWS = 17;
    stim_row_t directed_rows [DIR_ROWS] = '{
        '{rmad_pkg::ACT_QUERY,  32'sd0,        32'sd0,        1'b1,
          rmad_pkg::ST_EMPTY, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_QUERY,  -32'sd1,       -32'sd1,       1'b1,
          rmad_pkg::ST_EMPTY, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_INSERT, 32'sh7fffffff, 32'sh7fffffff, 1'b1,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_QUERY,  32'sd0,        32'sd0,        1'b1,
          rmad_pkg::ST_OK, 32'sh7fffffff, 44'sd2147483647},
        '{rmad_pkg::ACT_INSERT, 32'sh80000000, 32'sh80000000, 1'b1,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_QUERY,  32'sd0,        32'sd0,        1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_INSERT, 32'sd5,        32'sd0,        1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_INSERT, 32'sd5,        -32'sd1,       1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_QUERY,  32'sd0,        32'sd0,        1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_INSERT, 32'sd5,        32'sd1,        1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_QUERY,  32'sh55555555, 32'shaaaaaaaa, 1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_INSERT, -32'sd1,       32'sd0,        1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_INSERT, 32'sd0,        32'sd0,        1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_QUERY,  32'sd0,        32'sd0,        1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_INSERT, 32'sh55555555, 32'shaaaaaaaa, 1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_INSERT, 32'shaaaaaaaa, 32'sh55555555, 1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0},
        '{rmad_pkg::ACT_QUERY,  32'sd0,        32'sd0,        1'b0,
          rmad_pkg::ST_OK, 32'sd0, 44'sd0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic signed [31:0] position;
    logic signed [31:0] offset;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [31:0] median;
    logic signed [43:0] min_value;

    running_median_abs_deviation dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .position  (position),
        .offset    (offset),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .median    (median),
        .min_value (min_value)
    );

    // predictor state: stored positions kept sorted, plus running totals
    longint  sorted_positions [$];
    longint  position_sum;
    longint  offset_sum;
    answer_t answers_due [$];
    int      mismatches  = 0;
    int      idle_cycles = 0;
    int      burst_left;

    function automatic answer_t median_predict(logic act, logic signed [31:0] pos,
                                               logic signed [31:0] off);
        answer_t ans;
        longint  a;
        longint  m;
        longint  low_sum;
        longint  f;
        int      n;
        int      low_n;
        int      idx;
        ans = '{rmad_pkg::ST_OK, 32'sd0, 44'sd0};
        n = sorted_positions.size();
        if (act == rmad_pkg::ACT_INSERT)
        begin
            if (n >= CAPACITY)
                ans.st = rmad_pkg::ST_FULL;
            else
            begin
                a = longint'(pos);
                idx = 0;
                while (idx < n && sorted_positions[idx] <= a)
                    idx++;
                sorted_positions.insert(idx, a);
                position_sum += a;
                offset_sum += longint'(off);
            end
        end
        else if (n == 0)
            ans.st = rmad_pkg::ST_EMPTY;
        else
        begin
            // lower half holds the smallest ceil(n/2) positions
            low_n = (n + 1) / 2;
            low_sum = 0;
            for (int i = 0; i < low_n; i++)
                low_sum += sorted_positions[i];
            m = sorted_positions[low_n - 1];
            f = position_sum + offset_sum + m - 2 * low_sum;
            if (n % 2 == 0)
                f -= m;
            ans.med = m[31:0];
            ans.mv  = f[43:0];
        end
        return ans;
    endfunction

    // one request: burst/gap shaping, then hold until accepted
    task automatic send_request(logic act, logic signed [31:0] pos, logic signed [31:0] off,
                                bit typed, answer_t typed_ans);
        answer_t ans;
        int      gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        action   <= act;
        position <= pos;
        offset   <= off;
        do
            @(posedge clk);
        while (in_stall);
        ans = median_predict(act, pos, off);
        answers_due.insert(answers_due.size(), typed ? typed_ans : ans);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return $urandom_range(0, 16) - 8;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        while (answers_due.size() != 0)
            @(posedge clk);
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: stall pattern cycles through calm, light and heavy phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            case (($time / 768) % 3)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        answer_t exp_ans;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                if (answers_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d median %0d min %0d",
                                 status, median, min_value);
                end
                else
                begin
                    exp_ans = answers_due.pop_front();
                    if (status !== exp_ans.st || median !== exp_ans.med
                        || min_value !== exp_ans.mv)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
                                     exp_ans.st, exp_ans.med, exp_ans.mv,
                                     status, median, min_value);
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        answer_t none;
        answer_t typed_ans;
        logic    act;
        none = '{rmad_pkg::ST_OK, 32'sd0, 44'sd0};
        position_sum = 0;
        offset_sum = 0;
        burst_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = rmad_pkg::ACT_INSERT;
        position = '0;
        offset = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_ans = '{directed_rows[i].st, directed_rows[i].med, directed_rows[i].mv};
            send_request(directed_rows[i].act, directed_rows[i].pos, directed_rows[i].off,
                         directed_rows[i].typed, typed_ans);
        end

        // sender holds off until all answers are in
        in_valid <= 1'b0;
        wait_drained();

        // random mix, mostly inserts so the store fills up
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            act = ($urandom_range(0, 7) < 7) ? rmad_pkg::ACT_INSERT : rmad_pkg::ACT_QUERY;
            send_request(act, pick_value(), pick_value(), 1'b0, none);
        end

        // fill to capacity, then inserts into a full store and queries
        while (sorted_positions.size() < CAPACITY)
            send_request(rmad_pkg::ACT_INSERT, pick_value(), pick_value(), 1'b0, none);
        for (int i = 0; i < 8; i++)
            send_request(i % 2 ? rmad_pkg::ACT_QUERY : rmad_pkg::ACT_INSERT,
                         pick_value(), pick_value(), 1'b0, none);
        in_valid <= 1'b0;

        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
